### hw/rtl/pwf_pkg.sv
// ----------------------------------------------------------------------------
// pwf_pkg
// Shared types and constants for the particle wind force update pipeline.
// ----------------------------------------------------------------------------
package pwf_pkg;

  localparam int unsigned SQRT_STEPS = 32;  // one root bit per stage
  localparam int unsigned DIV_STEPS  = 30;  // quotient bits after the leading one

  localparam logic [30:0] RADIUS_RST = 31'd65536;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

  typedef enum logic [2:0] {
    CFG_MODE     = 3'd0,
    CFG_VEC_X    = 3'd1,
    CFG_VEC_Y    = 3'd2,
    CFG_VEC_Z    = 3'd3,
    CFG_RADIUS   = 3'd4,
    CFG_STRENGTH = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    MODE_RADIAL = 1'b0,
    MODE_DIRECT = 1'b1
  } force_mode_e;

  typedef struct packed {
    force_mode_e      force_mode;
    logic [2:0][31:0] vec;
    logic [30:0]      radius;
    logic [31:0]      strength;
  } cfg_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;
  } in_t;

  typedef struct packed {
    logic [31:0] new_vel_x;
    logic [31:0] new_vel_y;
    logic [31:0] new_vel_z;
    logic        saturated;
  } out_t;

  // velocity and offset signs ride along the whole pipe
  typedef struct packed {
    logic [2:0][31:0] vel;
    logic [2:0]       neg;
  } tail_t;

  typedef struct packed {
    logic [63:0]      sum;
    logic [2:0][30:0] mag;
    logic [1:0]       sh;
    tail_t            tail;
  } front_t;

  typedef struct packed {
    logic [31:0]      root;
    logic [2:0][30:0] mag;
    logic [1:0]       sh;
    tail_t            tail;
  } root_t;

  typedef struct packed {
    logic             ge;
    logic [29:0]      fq;
    logic             lzero;
    logic [2:0][30:0] uq;
    tail_t            tail;
  } quot_t;

endpackage

### hw/rtl/pwf_front.sv
// ----------------------------------------------------------------------------
// pwf_front
// Offset to center, magnitude and prescale, squares and sum of squares.
// ----------------------------------------------------------------------------
module pwf_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  pwf_pkg::in_t   data_i,
  input  pwf_pkg::cfg_t  cfg_i,
  output logic           valid_o,
  output pwf_pkg::front_t data_o
);

  logic [2:0][31:0] pos;
  logic [2:0][32:0] d_d, d_q;
  pwf_pkg::tail_t   a_tail_q;
  logic             a_vld_q;

  logic [2:0][32:0] mag;
  logic             hi2, hi1;
  logic [1:0]       sh_d, b_sh_q;
  logic [2:0][30:0] sm_d, b_mag_q, c_mag_q;
  pwf_pkg::tail_t   b_tail_d, b_tail_q, c_tail_q;
  logic [1:0]       c_sh_q;
  logic             b_vld_q, c_vld_q, d_vld_q;
  logic [2:0][61:0] sq_d, sq_q;
  logic [63:0]      sum_d;

  assign pos[0] = data_i.pos_x;
  assign pos[1] = data_i.pos_y;
  assign pos[2] = data_i.pos_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_d[i] = {cfg_i.vec[i][31], cfg_i.vec[i]} - {pos[i][31], pos[i]};
    end
  end

  always_comb begin
    hi2 = 1'b0;
    hi1 = 1'b0;
    b_tail_d = a_tail_q;
    for (int i = 0; i < 3; i++) begin
      mag[i] = d_q[i][32] ? (~d_q[i] + 33'd1) : d_q[i];
      b_tail_d.neg[i] = d_q[i][32];
      hi2 = hi2 | mag[i][32];
      hi1 = hi1 | mag[i][31];
    end
    sh_d = hi2 ? 2'd2 : (hi1 ? 2'd1 : 2'd0);
    for (int i = 0; i < 3; i++) begin
      sm_d[i] = 31'(mag[i] >> sh_d);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = 62'(b_mag_q[i]) * 62'(b_mag_q[i]);
    end
  end

  assign sum_d = 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q           <= d_d;
      a_tail_q.vel  <= {data_i.vel_z, data_i.vel_y, data_i.vel_x};
      a_tail_q.neg  <= '0;
      b_mag_q       <= sm_d;
      b_sh_q        <= sh_d;
      b_tail_q      <= b_tail_d;
      sq_q          <= sq_d;
      c_mag_q       <= b_mag_q;
      c_sh_q        <= b_sh_q;
      c_tail_q      <= b_tail_q;
      data_o.sum    <= sum_d;
      data_o.mag    <= c_mag_q;
      data_o.sh     <= c_sh_q;
      data_o.tail   <= c_tail_q;
    end
  end

  assign valid_o = d_vld_q;

endmodule

### hw/rtl/pwf_sqrt.sv
// ----------------------------------------------------------------------------
// pwf_sqrt
// Digit-by-digit integer square root, one root bit per pipeline stage.
// ----------------------------------------------------------------------------
module pwf_sqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  pwf_pkg::front_t data_i,
  output logic            valid_o,
  output pwf_pkg::root_t  data_o
);

  localparam int unsigned N = pwf_pkg::SQRT_STEPS;

  logic [N:0]       vld;
  logic [63:0]      rem [N+1];
  logic [63:0]      res [N+1];
  logic [2:0][30:0] mag [N+1];
  logic [1:0]       sh  [N+1];
  pwf_pkg::tail_t   tl  [N+1];

  assign vld[0] = valid_i;
  assign rem[0] = data_i.sum;
  assign res[0] = '0;
  assign mag[0] = data_i.mag;
  assign sh[0]  = data_i.sh;
  assign tl[0]  = data_i.tail;

  for (genvar j = 0; j < N; j++) begin : g_step
    localparam logic [63:0] Bit = 64'd1 << (2 * (N - 1 - j));
    logic [64:0] trial;
    logic        take;
    logic [63:0] rem_d, res_d;

    always_comb begin
      trial = {1'b0, res[j]} + {1'b0, Bit};
      take  = {1'b0, rem[j]} >= trial;
      rem_d = take ? (rem[j] - trial[63:0]) : rem[j];
      res_d = take ? ((res[j] >> 1) + Bit) : (res[j] >> 1);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[j+1] <= 1'b0;
      end else if (en_i) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem[j+1] <= rem_d;
        res[j+1] <= res_d;
        mag[j+1] <= mag[j];
        sh[j+1]  <= sh[j];
        tl[j+1]  <= tl[j];
      end
    end
  end

  assign valid_o     = vld[N];
  assign data_o.root = res[N][31:0];
  assign data_o.mag  = mag[N];
  assign data_o.sh   = sh[N];
  assign data_o.tail = tl[N];

endmodule

### hw/rtl/pwf_div.sv
// ----------------------------------------------------------------------------
// pwf_div
// Restoring dividers: distance over radius and unit direction per axis,
// one quotient bit per stage for all four lanes.
// ----------------------------------------------------------------------------
module pwf_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  pwf_pkg::root_t data_i,
  input  pwf_pkg::cfg_t  cfg_i,
  output logic           valid_o,
  output pwf_pkg::quot_t data_o
);

  localparam int unsigned N = pwf_pkg::DIV_STEPS;

  logic [N:0]       vld;
  logic             ge    [N+1];
  logic [31:0]      frem  [N+1];
  logic [29:0]      fq    [N+1];
  logic             lzero [N+1];
  logic [31:0]      len   [N+1];
  logic [2:0][31:0] urem  [N+1];
  logic [2:0][30:0] uq    [N+1];
  pwf_pkg::tail_t   tl    [N+1];

  // leading stage: range check for f, top quotient bit for each axis
  logic [33:0]      distance;
  logic             ge_d;
  logic [2:0][32:0] ur0;
  logic [2:0][31:0] urem_d;
  logic [2:0][30:0] uq_d;

  always_comb begin
    distance = 34'(data_i.root) << data_i.sh;
    ge_d = distance >= {3'b0, cfg_i.radius};
    for (int i = 0; i < 3; i++) begin
      ur0[i] = {2'b0, data_i.mag[i]};
      if (ur0[i] >= {1'b0, data_i.root}) begin
        urem_d[i] = 32'(ur0[i] - {1'b0, data_i.root});
        uq_d[i]   = 31'd1;
      end else begin
        urem_d[i] = ur0[i][31:0];
        uq_d[i]   = 31'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld[0] <= 1'b0;
    end else if (en_i) begin
      vld[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ge[0]    <= ge_d;
      frem[0]  <= ge_d ? 32'd0 : {1'b0, distance[30:0]};
      fq[0]    <= '0;
      lzero[0] <= data_i.root == 32'd0;
      len[0]   <= data_i.root;
      urem[0]  <= urem_d;
      uq[0]    <= uq_d;
      tl[0]    <= data_i.tail;
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_step
    logic [31:0]      fr2;
    logic             ftake;
    logic [2:0][32:0] ur2;
    logic [2:0]       utake;
    logic [2:0][31:0] urem_n;
    logic [2:0][30:0] uq_n;

    always_comb begin
      fr2   = {frem[k-1][30:0], 1'b0};
      ftake = fr2 >= {1'b0, cfg_i.radius};
      for (int i = 0; i < 3; i++) begin
        ur2[i]    = {urem[k-1][i], 1'b0};
        utake[i]  = ur2[i] >= {1'b0, len[k-1]};
        urem_n[i] = utake[i] ? 32'(ur2[i] - {1'b0, len[k-1]}) : ur2[i][31:0];
        uq_n[i]   = {uq[k-1][i][29:0], utake[i]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k] <= 1'b0;
      end else if (en_i) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ge[k]    <= ge[k-1];
        frem[k]  <= ftake ? (fr2 - {1'b0, cfg_i.radius}) : fr2;
        fq[k]    <= {fq[k-1][28:0], ftake};
        lzero[k] <= lzero[k-1];
        len[k]   <= len[k-1];
        urem[k]  <= urem_n;
        uq[k]    <= uq_n;
        tl[k]    <= tl[k-1];
      end
    end
  end

  assign valid_o      = vld[N];
  assign data_o.ge    = ge[N];
  assign data_o.fq    = fq[N];
  assign data_o.lzero = lzero[N];
  assign data_o.uq    = uq[N];
  assign data_o.tail  = tl[N];

endmodule

### hw/rtl/pwf_back.sv
// ----------------------------------------------------------------------------
// pwf_back
// Falloff, strength scaling, per-axis delta and saturating velocity sum.
// ----------------------------------------------------------------------------
module pwf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  pwf_pkg::quot_t data_i,
  input  pwf_pkg::cfg_t  cfg_i,
  output logic           valid_o,
  output pwf_pkg::out_t  data_o
);

  logic             s1_vld_q, s2_vld_q, s3_vld_q, out_vld_q;
  logic [30:0]      f;
  logic [2:0][30:0] u_d, s1_u_q, s2_u_q;
  logic [61:0]      ff_q;
  pwf_pkg::tail_t   s1_tail_q, s2_tail_q, s3_tail_q;

  logic [30:0]      g;
  logic [31:0]      st_mag;
  logic [62:0]      kp;
  logic [31:0]      k_q;

  logic [2:0][62:0] mp;
  logic [2:0][31:0] m_q;

  logic [2:0][32:0] delta;
  logic [2:0][33:0] sum;
  logic [2:0]       clip;
  logic [2:0][31:0] nv;

  always_comb begin
    f = data_i.ge ? pwf_pkg::ONE_Q30 : {1'b0, data_i.fq};
    for (int i = 0; i < 3; i++) begin
      u_d[i] = data_i.lzero ? 31'd0 : data_i.uq[i];
    end
  end

  always_comb begin
    g      = pwf_pkg::ONE_Q30 - ff_q[60:30];
    st_mag = cfg_i.strength[31] ? (~cfg_i.strength + 32'd1) : cfg_i.strength;
    kp     = 63'(st_mag) * 63'(g);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mp[i] = 63'(k_q) * 63'(s2_u_q[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cfg_i.force_mode == pwf_pkg::MODE_DIRECT) begin
        delta[i] = {cfg_i.vec[i][31], cfg_i.vec[i]};
      end else if (cfg_i.strength[31] ^ s3_tail_q.neg[i]) begin
        delta[i] = ~{1'b0, m_q[i]} + 33'd1;
      end else begin
        delta[i] = {1'b0, m_q[i]};
      end
      sum[i]  = {{2{s3_tail_q.vel[i][31]}}, s3_tail_q.vel[i]} + {delta[i][32], delta[i]};
      clip[i] = (sum[i][33:31] != 3'b000) && (sum[i][33:31] != 3'b111);
      nv[i]   = clip[i] ? (sum[i][33] ? 32'h8000_0000 : 32'h7fff_ffff) : sum[i][31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q  <= valid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      out_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ff_q             <= 62'(f) * 62'(f);
      s1_u_q           <= u_d;
      s1_tail_q        <= data_i.tail;
      k_q              <= kp[61:30];
      s2_u_q           <= s1_u_q;
      s2_tail_q        <= s1_tail_q;
      m_q[0]           <= mp[0][61:30];
      m_q[1]           <= mp[1][61:30];
      m_q[2]           <= mp[2][61:30];
      s3_tail_q        <= s2_tail_q;
      data_o.new_vel_x <= nv[0];
      data_o.new_vel_y <= nv[1];
      data_o.new_vel_z <= nv[2];
      data_o.saturated <= |clip;
    end
  end

  assign valid_o = out_vld_q;

endmodule

### hw/rtl/particle_wind_force_update.sv
// ----------------------------------------------------------------------------
// particle_wind_force_update
// Applies one external force (radial or directional) to a particle stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries position and velocity of one
//   particle per transaction; output channel out_valid_o/out_ready_i carries
//   the updated, saturated velocity. Config registers are written through
//   cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must write them only while no
//   transaction is in flight, the block does not enforce this. There are 4
//   front stages, 32 square-root stages (one root bit each), 31 divider
//   stages (one quotient bit each) and 4 back stages ending in the output
//   register. Throughput is one particle per cycle while out_ready_i is high.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_ready_o drops; nothing is lost or repeated.
//   Reset clears all pipeline valid bits and sets force_mode radial, vec 0,
//   radius 1.0 and strength 0.
// ----------------------------------------------------------------------------
module particle_wind_force_update (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pwf_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pwf_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [31:0]   cfg_wdata_i
);

  pwf_pkg::cfg_t   cfg_q;
  logic            en;
  logic            fr_vld, sq_vld, dv_vld;
  pwf_pkg::front_t fr_data;
  pwf_pkg::root_t  sq_data;
  pwf_pkg::quot_t  dv_data;

  // whole pipe advances unless a finished result is blocked
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.force_mode <= pwf_pkg::MODE_RADIAL;
      cfg_q.vec        <= '0;
      cfg_q.radius     <= pwf_pkg::RADIUS_RST;
      cfg_q.strength   <= '0;
    end else if (cfg_we_i) begin
      case (pwf_pkg::cfg_idx_e'(cfg_idx_i))
        pwf_pkg::CFG_MODE:     cfg_q.force_mode <= pwf_pkg::force_mode_e'(cfg_wdata_i[0]);
        pwf_pkg::CFG_VEC_X:    cfg_q.vec[0]     <= cfg_wdata_i;
        pwf_pkg::CFG_VEC_Y:    cfg_q.vec[1]     <= cfg_wdata_i;
        pwf_pkg::CFG_VEC_Z:    cfg_q.vec[2]     <= cfg_wdata_i;
        pwf_pkg::CFG_RADIUS:   cfg_q.radius     <= cfg_wdata_i[30:0];
        pwf_pkg::CFG_STRENGTH: cfg_q.strength   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  pwf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .cfg_i   (cfg_q),
    .valid_o (fr_vld),
    .data_o  (fr_data)
  );

  pwf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_vld),
    .data_i  (fr_data),
    .valid_o (sq_vld),
    .data_o  (sq_data)
  );

  pwf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .data_i  (sq_data),
    .cfg_i   (cfg_q),
    .valid_o (dv_vld),
    .data_o  (dv_data)
  );

  pwf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_vld),
    .data_i  (dv_data),
    .cfg_i   (cfg_q),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // a clipped result must sit at one of the 32-bit rails
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |->
      out_data_o.new_vel_x == 32'h7fff_ffff || out_data_o.new_vel_x == 32'h8000_0000 ||
      out_data_o.new_vel_y == 32'h7fff_ffff || out_data_o.new_vel_y == 32'h8000_0000 ||
      out_data_o.new_vel_z == 32'h7fff_ffff || out_data_o.new_vel_z == 32'h8000_0000)
    else $error("saturated flag without a clipped component");

  a_radius_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == pwf_pkg::CFG_RADIUS |=>
      cfg_q.radius == $past(cfg_wdata_i[30:0]))
    else $error("radius write not taken");
`endif

endmodule
